@@ rtl/crcwf_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// crcwf_pkg
// shared types and constants for the crc16 word framer
// ----------------------------------------------------------------------------
package crcwf_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned WORD_W = 16;
    localparam int unsigned CRC_W  = 16;
    localparam int unsigned CFG_ADDR_W = 1;

    // reflected crc-16 polynomial, kermit form
    localparam logic [CRC_W-1:0] CRC_POLY = 16'h8408;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_START_BYTE = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_END_BYTE   = 1'b1;

    // request to the crc unit
    typedef struct packed {
        logic              clear;
        logic              update;
        logic [BYTE_W-1:0] data;
    } crc_ctl_t;

endpackage

`default_nettype wire

@@ rtl/crcwf_crc.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// crcwf_crc
// running reflected crc-16, one byte folded in per cycle while update is asserted
// ----------------------------------------------------------------------------
module crcwf_crc (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire crcwf_pkg::crc_ctl_t            ctl,
    output logic [crcwf_pkg::CRC_W-1:0]         crc
);

    logic [crcwf_pkg::CRC_W-1:0] crc_reg;
    logic [crcwf_pkg::CRC_W-1:0] crc_next;
    logic [crcwf_pkg::CRC_W-1:0] fold;

    // eight shift steps of the bitwise reflected update
    always_comb begin
        fold = crc_reg ^ {{(crcwf_pkg::CRC_W - crcwf_pkg::BYTE_W){1'b0}}, ctl.data};
        for (int k = 0; k < crcwf_pkg::BYTE_W; k++) begin
            if (fold[0]) begin
                fold = (fold >> 1) ^ crcwf_pkg::CRC_POLY;
            end else begin
                fold = fold >> 1;
            end
        end
    end

    always_comb begin
        if (ctl.clear) begin
            crc_next = '0;
        end else if (ctl.update) begin
            crc_next = fold;
        end else begin
            crc_next = crc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= '0;
        end else begin
            crc_reg <= crc_next;
        end
    end

    assign crc = crc_reg;

endmodule

`default_nettype wire

@@ rtl/crc16_word_framer_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// crc16_word_framer_top
// frames signed 16-bit words into a byte stream closed by a crc-16 (kermit)
// ----------------------------------------------------------------------------
// a request's first byte goes from the held request regs into the output register
// throughput: one byte per cycle while the receiver stays ready; a plain word gives 2 bytes,
//   plus 1 for a start byte and 3 for the crc and end bytes
// the next request is taken in the cycle its predecessor's final byte enters the output register
// reset: synchronous active-low aresetn clears control, crc and config regs
// ----------------------------------------------------------------------------
module crc16_word_framer_top (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // configuration write port
    input  wire logic                                cfg_we,
    input  wire logic [crcwf_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [crcwf_pkg::BYTE_W-1:0]        cfg_wdata,
    // input word stream
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [crcwf_pkg::WORD_W-1:0]        s_tdata,   // [15:0] data_word
    input  wire logic                                s_tuser,   // [0] first_word
    input  wire logic                                s_tlast,   // last_word
    // output byte stream
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [crcwf_pkg::BYTE_W-1:0]             m_tdata,   // [7:0] out_byte
    output logic                                     m_tlast    // end_of_frame
);

    // byte position within the bytes caused by one request
    typedef enum logic [2:0] {
        STEP_START,
        STEP_LO,
        STEP_HI,
        STEP_CRC_LO,
        STEP_CRC_HI,
        STEP_END
    } step_t;

    // configuration registers
    logic [crcwf_pkg::BYTE_W-1:0] start_byte_reg;
    logic [crcwf_pkg::BYTE_W-1:0] end_byte_reg;

    // held request
    logic [crcwf_pkg::WORD_W-1:0] word_reg;
    logic                         last_reg;
    logic                         busy_reg;
    step_t                        step_reg;

    // output register
    logic                         m_tvalid_reg;
    logic [crcwf_pkg::BYTE_W-1:0] m_tdata_reg;
    logic                         m_tlast_reg;

    logic                         advance;
    logic                         final_byte;
    logic [crcwf_pkg::BYTE_W-1:0] cur_byte;
    logic                         accept;
    logic [crcwf_pkg::CRC_W-1:0]  crc;
    crcwf_pkg::crc_ctl_t          crc_ctl;

    // config writes, taken at any time
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_byte_reg <= '0;
            end_byte_reg   <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                crcwf_pkg::CFG_START_BYTE: start_byte_reg <= cfg_wdata;
                crcwf_pkg::CFG_END_BYTE:   end_byte_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // a byte moves into the output register when it is empty or draining
    assign advance    = busy_reg && (!m_tvalid_reg || m_tready);
    assign final_byte = last_reg ? (step_reg == STEP_END) : (step_reg == STEP_HI);
    assign s_tready   = !busy_reg || (advance && final_byte);
    assign accept     = s_tvalid && s_tready;

    // byte for the current step
    always_comb begin
        case (step_reg)
            STEP_START:  cur_byte = start_byte_reg;
            STEP_LO:     cur_byte = word_reg[crcwf_pkg::BYTE_W-1:0];
            STEP_HI:     cur_byte = word_reg[crcwf_pkg::WORD_W-1:crcwf_pkg::BYTE_W];
            STEP_CRC_LO: cur_byte = crc[crcwf_pkg::BYTE_W-1:0];
            STEP_CRC_HI: cur_byte = crc[crcwf_pkg::CRC_W-1:crcwf_pkg::BYTE_W];
            STEP_END:    cur_byte = end_byte_reg;
            default:     cur_byte = '0;
        endcase
    end

    // crc restarts on the start byte and after the end byte
    always_comb begin
        crc_ctl.clear  = advance && (step_reg == STEP_START || step_reg == STEP_END);
        crc_ctl.update = advance && (step_reg == STEP_LO || step_reg == STEP_HI);
        crc_ctl.data   = cur_byte;
    end

    crcwf_crc u_crc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (crc_ctl),
        .crc     (crc)
    );

    // request sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= STEP_LO;
            last_reg <= 1'b0;
        end else if (accept) begin
            busy_reg <= 1'b1;
            last_reg <= s_tlast;
            step_reg <= s_tuser ? STEP_START : STEP_LO;
        end else if (advance) begin
            if (final_byte) begin
                busy_reg <= 1'b0;
            end else begin
                case (step_reg)
                    STEP_START:  step_reg <= STEP_LO;
                    STEP_LO:     step_reg <= STEP_HI;
                    STEP_HI:     step_reg <= STEP_CRC_LO;
                    STEP_CRC_LO: step_reg <= STEP_CRC_HI;
                    STEP_CRC_HI: step_reg <= STEP_END;
                    default:     step_reg <= STEP_LO;
                endcase
            end
        end
    end

    // payload of the held request
    always_ff @(posedge aclk) begin
        if (accept) begin
            word_reg <= s_tdata;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_tdata_reg <= cur_byte;
            m_tlast_reg <= (step_reg == STEP_END);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

@@ tb/sv/crc16_frame_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// crc16_frame_checker
// watches both streams of the word framer and checks every output byte
// ----------------------------------------------------------------------------
// mirrors the config writes, predicts the framed byte sequence of each
// accepted word with its own crc-16 (kermit) and compares each output
// byte in order against the oldest prediction
// ----------------------------------------------------------------------------
module crc16_frame_checker (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_we,
    input  wire logic [crcwf_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [crcwf_pkg::BYTE_W-1:0]        cfg_wdata,
    input  wire logic                                s_tvalid,
    input  wire logic                                s_tready,
    input  wire logic [crcwf_pkg::WORD_W-1:0]        s_tdata,   // [15:0] data_word
    input  wire logic                                s_tuser,   // [0] first_word
    input  wire logic                                s_tlast,
    input  wire logic                                m_tvalid,
    input  wire logic                                m_tready,
    input  wire logic [crcwf_pkg::BYTE_W-1:0]        m_tdata,   // [7:0] out_byte
    input  wire logic                                m_tlast,
    output int unsigned                              mismatch_count,
    output int unsigned                              bytes_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import crcwf_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              end_of_frame;
    } frame_byte_t;

    frame_byte_t       expected_bytes[$];
    logic [CRC_W-1:0]  frame_crc;
    logic [BYTE_W-1:0] start_marker;
    logic [BYTE_W-1:0] end_marker;

    function automatic logic [CRC_W-1:0] crc_fold_byte(input logic [CRC_W-1:0] crc,
                                                       input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        int k;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (k = 0; k < BYTE_W; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    task automatic predict_word_bytes(input logic [WORD_W-1:0] word, input logic first,
                                      input logic last);
        logic [BYTE_W-1:0] lo;
        logic [BYTE_W-1:0] hi;
        lo = word[BYTE_W-1:0];
        hi = word[WORD_W-1:BYTE_W];
        if (first) begin
            frame_crc = '0;
            expected_bytes.push_back({start_marker, 1'b0});
        end
        expected_bytes.push_back({lo, 1'b0});
        expected_bytes.push_back({hi, 1'b0});
        frame_crc = crc_fold_byte(frame_crc, lo);
        frame_crc = crc_fold_byte(frame_crc, hi);
        if (last) begin
            expected_bytes.push_back({frame_crc[BYTE_W-1:0], 1'b0});
            expected_bytes.push_back({frame_crc[CRC_W-1:BYTE_W], 1'b0});
            expected_bytes.push_back({end_marker, 1'b1});
            frame_crc = '0;
        end
    endtask

    always @(posedge aclk) begin
        frame_byte_t want;
        if (!aresetn) begin
            frame_crc    = '0;
            start_marker = '0;
            end_marker   = '0;
            expected_bytes.delete();
        end else begin
            // output side first: a byte leaving now belongs to an older request
            if (m_tvalid && m_tready) begin
                if (expected_bytes.size() == 0) begin
                    $display("%0t: unexpected byte, expected none, actual %02h/%b",
                             $time, m_tdata, m_tlast);
                    mismatch_count++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (want.out_byte !== m_tdata || want.end_of_frame !== m_tlast) begin
                        $display("%0t: byte mismatch, expected %02h/%b, actual %02h/%b",
                                 $time, want.out_byte, want.end_of_frame, m_tdata, m_tlast);
                        mismatch_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_word_bytes(s_tdata, s_tuser, s_tlast);
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_START_BYTE: start_marker = cfg_wdata;
                    CFG_END_BYTE:   end_marker   = cfg_wdata;
                    default: ;
                endcase
            end
        end
        bytes_outstanding = expected_bytes.size();
    end

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for the crc16 word framer
// ----------------------------------------------------------------------------
// drives directed and random word requests, frames mostly well formed,
// with random idling on both streams and several start/end byte settings;
// a separate checker predicts and compares every output byte
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import crcwf_pkg::*;

    // generous bound on the whole run, far above the slowest legal run
    localparam int unsigned CYCLE_LIMIT     = 600000;
    // receiver hold-off long enough to back the block up to its input
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    // quiet cycles after the last byte before touching config or finishing
    localparam int unsigned SETTLE_CYCLES   = 4;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = CFG_START_BYTE;
    logic [BYTE_W-1:0]     cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [WORD_W-1:0]     s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [BYTE_W-1:0]     m_tdata;
    logic                  m_tlast;

    int unsigned mismatch_count;
    int unsigned bytes_outstanding;
    int unsigned cycle_count = 0;

    // steady_flow: no idling on either side; hold_off_req: one long receiver stall
    bit steady_flow  = 1'b0;
    bit hold_off_req = 1'b0;

    always #10 aclk = ~aclk;

    crc16_word_framer_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    crc16_frame_checker frame_check (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_addr          (cfg_addr),
        .cfg_wdata         (cfg_wdata),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .s_tuser           (s_tuser),
        .s_tlast           (s_tlast),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .m_tlast           (m_tlast),
        .mismatch_count    (mismatch_count),
        .bytes_outstanding (bytes_outstanding)
    );

    // idle length: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, 40);
    endfunction

    // data word with the signed extremes and all-zero / all-one mixed in
    function automatic logic [WORD_W-1:0] pick_word();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 16'h8000;
        else if (r < 16)
            return 16'h7FFF;
        else if (r < 20)
            return 16'h0000;
        else if (r < 24)
            return 16'hFFFF;
        else
            return WORD_W'($urandom);
    endfunction

    // one word request, preceded by a random gap unless the flow is steady
    task automatic send_word(input logic [WORD_W-1:0] word, input logic first,
                             input logic last);
        int unsigned gap;
        gap = steady_flow ? 0 : pick_gap();
        if (gap != 0) begin
            // junk on the bus while tvalid is low
            s_tvalid <= 1'b0;
            s_tdata  <= WORD_W'($urandom);
            s_tuser  <= 1'($urandom);
            s_tlast  <= 1'($urandom);
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= first;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // sender pauses until every predicted byte has left the block
    task automatic drain_frames();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (bytes_outstanding != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [BYTE_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        cfg_wdata <= BYTE_W'($urandom);
        @(negedge aclk);
    endtask

    task automatic set_markers(input logic [BYTE_W-1:0] start_value,
                               input logic [BYTE_W-1:0] end_value);
        write_reg(CFG_START_BYTE, start_value);
        write_reg(CFG_END_BYTE, end_value);
    endtask

    // mostly well-formed frames with random content, some stray words with
    // random marks; returns once about n_words requests have gone
    task automatic random_traffic(input int unsigned n_words);
        int unsigned sent;
        int unsigned len;
        int unsigned i;
        sent = 0;
        while (sent < n_words) begin
            if ($urandom_range(0, 99) < 80) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16)
                                                  : $urandom_range(1, 6);
                for (i = 0; i < len; i++)
                    send_word(pick_word(), i == 0, i == len - 1);
                sent += len;
            end else begin
                send_word(pick_word(), 1'($urandom), 1'($urandom));
                sent++;
            end
        end
    endtask

    // receiver: random ready bursts and stalls, one long hold-off on request
    initial begin
        int unsigned span;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            if (hold_off_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
                hold_off_req = 1'b0;
            end else if (steady_flow || $urandom_range(0, 99) < 65) begin
                m_tready <= 1'b1;
                span = steady_flow ? 1 : $urandom_range(1, 12);
                repeat (span) @(negedge aclk);
            end else begin
                m_tready <= 1'b0;
                span = pick_gap();
                if (span == 0)
                    span = 1;
                repeat (span) @(negedge aclk);
            end
        end
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // -- directed part --
        // reset markers still zero; stray word right after reset, then a
        // frame closed without ever being opened
        send_word(16'h5555, 1'b0, 1'b0);
        send_word(16'h00A5, 1'b0, 1'b1);
        drain_frames();

        set_markers(8'hFF, 8'h00);
        // one-word frames at the field extremes
        send_word(16'h8000, 1'b1, 1'b1);
        send_word(16'h7FFF, 1'b1, 1'b1);
        send_word(16'h0000, 1'b1, 1'b1);
        send_word(16'hFFFF, 1'b1, 1'b1);
        // four-word frame with no idling on either side
        steady_flow = 1'b1;
        send_word(16'h1234, 1'b1, 1'b0);
        send_word(16'h00FF, 1'b0, 1'b0);
        send_word(16'hFF00, 1'b0, 1'b0);
        send_word(16'hAAAA, 1'b0, 1'b1);
        steady_flow = 1'b0;
        // frame lacking its first mark after a close: crc starts from zero
        send_word(16'h0F0F, 1'b0, 1'b0);
        send_word(16'hF0F0, 1'b0, 1'b1);
        // first mark inside an open frame restarts the crc
        send_word(16'h1111, 1'b1, 1'b0);
        send_word(16'h2222, 1'b1, 1'b0);
        send_word(16'h3333, 1'b0, 1'b1);
        drain_frames();

        set_markers(8'h00, 8'hFF);
        send_word(16'h8001, 1'b1, 1'b1);
        send_word(16'hFFFE, 1'b1, 1'b1);
        send_word(16'h4000, 1'b1, 1'b0);
        send_word(16'hC000, 1'b0, 1'b1);
        drain_frames();

        // -- random part, one setting per phase --
        set_markers(BYTE_W'($urandom), BYTE_W'($urandom));
        random_traffic(80);
        drain_frames();

        // long receiver hold-off while requests keep coming
        set_markers(8'hFF, 8'hFF);
        hold_off_req = 1'b1;
        random_traffic(80);
        drain_frames();

        // a stretch with no idling, then normal traffic
        set_markers(8'h00, 8'h00);
        steady_flow = 1'b1;
        random_traffic(40);
        steady_flow = 1'b0;
        random_traffic(40);
        drain_frames();

        set_markers(BYTE_W'($urandom), BYTE_W'($urandom));
        random_traffic(80);
        drain_frames();

        set_markers(8'h7E, 8'h7D);
        random_traffic(80);
        drain_frames();

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
